### rtl/lcps_pkg.sv
// Shared constants, types and helpers for the line-centroid PID steering core.
`timescale 1ns / 1ps
package lcps_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int HSUM_W = $clog2(SENSOR_COUNT * SENSOR_COUNT) + 2;
   localparam int SCNT_W = $clog2(SENSOR_COUNT + 1);

   localparam int ACC_W = 64;
   localparam int MPL_W = 20;
   localparam int QUO_W = 56;
   localparam int DVSR_W = 28;
   localparam int SUM_W = 48;
   localparam int STEP_W = 6;
   localparam int MUL_STEPS = MPL_W;
   localparam int DIV_STEPS = QUO_W;

   localparam logic [MPL_W-1:0] US_PER_S = 20'd1000000;
   localparam logic [DVSR_W-1:0] I_DIVISOR = 28'd256000000;

   localparam logic [2:0] CSR_GAIN_P = 3'd0;
   localparam logic [2:0] CSR_GAIN_I = 3'd1;
   localparam logic [2:0] CSR_GAIN_D = 3'd2;
   localparam logic [2:0] CSR_TIMESTEP = 3'd3;
   localparam logic [2:0] CSR_SPEED = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SCAN, ST_E_SET, ST_E_DIV, ST_P_SET, ST_P_MUL, ST_T_SET, ST_T_MUL,
      ST_INT_UPD, ST_I_SET, ST_I_MUL, ST_I_DSET, ST_I_DIV, ST_D_SET, ST_D_MUL1,
      ST_D_SET2, ST_D_MUL2, ST_D_DSET, ST_D_DIV, ST_D_FIN, ST_SUM, ST_OUT
   } state_type;

   function automatic logic [15:0] abs16(input logic signed [15:0] v);
      return v[15] ? 16'(-v) : 16'(v);
   endfunction

   function automatic logic signed [SUM_W-1:0] apply_sign(input logic [SUM_W-2:0] m,
                                                          input logic n);
      logic signed [SUM_W-1:0] s;
      s = $signed({1'b0, m});
      return n ? -s : s;
   endfunction

   function automatic logic signed [15:0] wheel_speed(input logic signed [25:0] v);
      logic [25:0] mag;
      logic signed [18:0] q;
      mag = v[25] ? 26'(-v) : 26'(v);
      q = $signed({1'b0, mag[25:8]});
      if (v[25]) begin
         q = -q;
      end
      if (q[18:15] != {4{q[18]}}) begin
         return q[18] ? 16'sh8000 : 16'sh7FFF;
      end
      return q[15:0];
   endfunction

endpackage

### rtl/line_centroid_pid_steering_core.sv
// Line-centroid PID steering core: sensor centroid, serial PID and wheel speeds.
`timescale 1ns / 1ps
// Usage:
//  - req_valid/req_ready carries one request of req_sensor_bits; it is taken
//    only while the core is idle.
//  - rsp_valid/rsp_ready returns one result per request: control_signal,
//    left_speed, right_speed and line_seen, held in an output register.
//  - Work is done by a shared bit-serial shift-add multiplier and a shared
//    bit-serial restoring divider. A request passes through the sensor scan
//    and the chain of five products and three quotients before rsp_valid;
//    the derivative products and quotient are skipped when the previous
//    error is zero. The core takes no new request until the result of the
//    last one is loaded; the next request can be taken in the cycle after
//    the result is loaded.
//  - A new request is accepted while an earlier result still waits in the
//    output register; the core only stalls at its final step if that result
//    has not been taken yet.
//  - csr_write_en writes csr_write_data to register csr_index at once; write
//    only while idle.
//  - reset restores register defaults and clears integral and previous error.
module line_centroid_pid_steering_core
   import lcps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_sensor_bits,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [23:0]  rsp_control_signal,
   output logic signed [15:0]  rsp_left_speed,
   output logic signed [15:0]  rsp_right_speed,
   output logic                rsp_line_seen,
   input  logic                csr_write_en,
   input  logic [2:0]          csr_index,
   input  logic [19:0]         csr_write_data
);

   state_type state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [SENSOR_COUNT-1:0] bits_ff, bits_in;
   logic signed [HSUM_W-1:0] hsum_ff, hsum_in;
   logic [SCNT_W-1:0] count_ff, count_in;
   logic [ACC_W-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [MPL_W-1:0] mplier_ff, mplier_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DVSR_W-1:0] rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic neg_ff, neg_in;
   logic signed [15:0] err_ff, err_in, prev_ff, prev_in;
   logic signed [39:0] integral_ff, integral_in;
   logic signed [SUM_W-1:0] p_ff, p_in, i_ff, i_in, d_ff, d_in;
   logic signed [23:0] sig_ff, sig_in;
   logic signed [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [19:0] ts_ff;
   logic [14:0] speed_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] rsp_sig_ff, rsp_sig_in;
   logic signed [15:0] rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic rsp_seen_ff, rsp_seen_in;

   logic [19:0] ts_eff;
   logic signed [HSUM_W-1:0] pos;
   logic [DVSR_W:0] trial;
   logic signed [41:0] isum, tval;
   logic signed [SUM_W-1:0] total;
   logic signed [16:0] diff;
   logic signed [25:0] base, lsum, rsum;

   assign ts_eff = (ts_ff == '0) ? 20'd1 : ts_ff;
   assign pos = $signed(HSUM_W'(2 * cnt_ff)) - HSUM_W'(SENSOR_COUNT - 1);
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign tval = neg_ff ? -$signed({1'b0, acc_ff[40:0]}) : $signed({1'b0, acc_ff[40:0]});
   assign isum = 42'(integral_ff) + tval;
   assign total = p_ff + i_ff + d_ff;
   assign diff = 17'(err_ff) - 17'(prev_ff);
   assign base = $signed({3'b000, speed_ff, 8'b0});
   assign lsum = base + 26'(sig_ff);
   assign rsum = base - 26'(sig_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= 16'sd256;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         ts_ff <= 20'd1000;
         speed_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GAIN_P: gain_p_ff <= csr_write_data[15:0];
            CSR_GAIN_I: gain_i_ff <= csr_write_data[15:0];
            CSR_GAIN_D: gain_d_ff <= csr_write_data[15:0];
            CSR_TIMESTEP: ts_ff <= csr_write_data;
            CSR_SPEED: speed_ff <= csr_write_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff <= '0;
         integral_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff <= prev_in;
         integral_ff <= integral_in;
      end
      cnt_ff <= cnt_in;
      bits_ff <= bits_in;
      hsum_ff <= hsum_in;
      count_ff <= count_in;
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvsr_ff <= dvsr_in;
      neg_ff <= neg_in;
      err_ff <= err_in;
      p_ff <= p_in;
      i_ff <= i_in;
      d_ff <= d_in;
      sig_ff <= sig_in;
      rsp_sig_ff <= rsp_sig_in;
      rsp_left_ff <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_seen_ff <= rsp_seen_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      bits_in = bits_ff;
      hsum_in = hsum_ff;
      count_in = count_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvsr_in = dvsr_ff;
      neg_in = neg_ff;
      err_in = err_ff;
      prev_in = prev_ff;
      integral_in = integral_ff;
      p_in = p_ff;
      i_in = i_ff;
      d_in = d_ff;
      sig_in = sig_ff;
      rsp_sig_in = rsp_sig_ff;
      rsp_left_in = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_seen_in = rsp_seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               bits_in = req_sensor_bits[SENSOR_COUNT-1:0];
               hsum_in = '0;
               count_in = '0;
               cnt_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (bits_ff[0]) begin
               hsum_in = hsum_ff + pos;
               count_in = count_ff + 1'b1;
            end
            bits_in = bits_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(SENSOR_COUNT - 1)) begin
               state_in = ST_E_SET;
            end
         end
         ST_E_SET: begin
            quo_in = QUO_W'(hsum_ff[HSUM_W-1] ? -hsum_ff : hsum_ff) << 7;
            rem_in = '0;
            dvsr_in = (count_ff == '0) ? DVSR_W'(1) : DVSR_W'(count_ff);
            neg_in = hsum_ff[HSUM_W-1];
            cnt_in = '0;
            state_in = ST_E_DIV;
         end
         ST_E_DIV, ST_I_DIV, ST_D_DIV: begin
            if (trial >= {1'b0, dvsr_ff}) begin
               rem_in = DVSR_W'(trial - {1'b0, dvsr_ff});
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DVSR_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               if (state_ff == ST_E_DIV) begin
                  state_in = ST_P_SET;
               end else if (state_ff == ST_I_DIV) begin
                  state_in = ST_D_SET;
               end else begin
                  state_in = ST_D_FIN;
               end
            end
         end
         ST_P_SET: begin
            err_in = neg_ff ? -$signed(quo_ff[15:0]) : $signed(quo_ff[15:0]);
            acc_in = '0;
            mcand_in = ACC_W'(quo_ff[15:0]);
            mplier_in = MPL_W'(abs16(gain_p_ff));
            neg_in = neg_ff ^ gain_p_ff[15];
            cnt_in = '0;
            state_in = ST_P_MUL;
         end
         ST_P_MUL, ST_T_MUL, ST_I_MUL, ST_D_MUL1, ST_D_MUL2: begin
            acc_in = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
            mcand_in = {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(MUL_STEPS - 1)) begin
               unique case (state_ff)
                  ST_P_MUL: state_in = ST_T_SET;
                  ST_T_MUL: state_in = ST_INT_UPD;
                  ST_I_MUL: state_in = ST_I_DSET;
                  ST_D_MUL1: state_in = ST_D_SET2;
                  default: state_in = ST_D_DSET;
               endcase
            end
         end
         ST_T_SET: begin
            p_in = apply_sign(acc_ff[SUM_W+6:8], neg_ff);
            acc_in = '0;
            mcand_in = ACC_W'(abs16(err_ff));
            mplier_in = ts_eff;
            neg_in = err_ff[15];
            cnt_in = '0;
            state_in = ST_T_MUL;
         end
         ST_INT_UPD: begin
            if (isum[41:39] != {3{isum[41]}}) begin
               integral_in = isum[41] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
            end else begin
               integral_in = isum[39:0];
            end
            state_in = ST_I_SET;
         end
         ST_I_SET: begin
            acc_in = '0;
            mcand_in = ACC_W'($unsigned(integral_ff[39] ? -integral_ff : integral_ff));
            mplier_in = MPL_W'(abs16(gain_i_ff));
            neg_in = integral_ff[39] ^ gain_i_ff[15];
            cnt_in = '0;
            state_in = ST_I_MUL;
         end
         ST_I_DSET, ST_D_DSET: begin
            quo_in = acc_ff[QUO_W-1:0];
            rem_in = '0;
            dvsr_in = (state_ff == ST_I_DSET) ? I_DIVISOR : {ts_eff, 8'b0};
            cnt_in = '0;
            state_in = (state_ff == ST_I_DSET) ? ST_I_DIV : ST_D_DIV;
         end
         ST_D_SET: begin
            i_in = apply_sign(quo_ff[SUM_W-2:0], neg_ff);
            prev_in = err_ff;
            if (prev_ff == '0) begin
               d_in = '0;
               state_in = ST_SUM;
            end else begin
               acc_in = '0;
               mcand_in = ACC_W'(diff[16] ? 17'(-diff) : 17'(diff));
               mplier_in = MPL_W'(abs16(gain_d_ff));
               neg_in = diff[16] ^ gain_d_ff[15];
               cnt_in = '0;
               state_in = ST_D_MUL1;
            end
         end
         ST_D_SET2: begin
            mcand_in = acc_ff;
            acc_in = '0;
            mplier_in = US_PER_S;
            cnt_in = '0;
            state_in = ST_D_MUL2;
         end
         ST_D_FIN: begin
            d_in = apply_sign(quo_ff[SUM_W-2:0], neg_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (total[SUM_W-1:23] != {(SUM_W - 23){total[SUM_W-1]}}) begin
               sig_in = total[SUM_W-1] ? 24'sh800000 : 24'sh7FFFFF;
            end else begin
               sig_in = total[23:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sig_in = sig_ff;
               rsp_left_in = wheel_speed(lsum);
               rsp_right_in = wheel_speed(rsum);
               rsp_seen_in = (count_ff != '0);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_control_signal = rsp_sig_ff;
   assign rsp_left_speed = rsp_left_ff;
   assign rsp_right_speed = rsp_right_ff;
   assign rsp_line_seen = rsp_seen_ff;

endmodule

### bench/line_centroid_pid_steering_core_tb.sv
// Self-checking testbench for the line-centroid PID steering core.
`timescale 1ns / 1ps
module line_centroid_pid_steering_core_tb;
   import lcps_pkg::*;

   typedef struct packed {
      logic signed [23:0] signal;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               seen;
   } steer_t;

   typedef struct {
      bit          is_csr;
      logic [2:0]  idx;
      logic [19:0] data;
      logic [7:0]  bits;
      bit          typed;
      steer_t      want;
   } row_t;

   localparam longint INTEG_MAX = 64'sd549755813887;
   localparam longint INTEG_MIN = -64'sd549755813888;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_sensor_bits = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_control_signal;
   logic signed [15:0] rsp_left_speed;
   logic signed [15:0] rsp_right_speed;
   logic               rsp_line_seen;
   logic               csr_write_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [19:0]        csr_write_data = '0;

   // predictor copy of registers and state
   logic signed [15:0] kp = 16'sd256, ki = '0, kd = '0;
   logic [19:0]        period_us = 20'd1000;
   logic [14:0]        base_speed = '0;
   longint             last_error = 0, integral = 0;

   steer_t steer_q[$];
   bit     cur_typed = 0;
   steer_t cur_want;
   int     accepted = 0, errors = 0;
   bit     no_idle = 0;
   row_t   rows[$];

   line_centroid_pid_steering_core DUT (.*);

   always #5 clock = ~clock;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic steer_t steer_predict(logic [7:0] bits);
      longint hs = 0, cnt = 0, err = 0, p, i, d, sig, base, ts;
      steer_t r;
      for (int n = 0; n < SENSOR_COUNT; n++) begin
         if (bits[n]) begin
            hs += 2 * n - (SENSOR_COUNT - 1);
            cnt++;
         end
      end
      if (cnt > 0) err = (hs * 128) / cnt;
      ts = (period_us == 0) ? 1 : longint'(period_us);
      p = (longint'(kp) * err) / 256;
      integral = clamp(integral + err * ts, INTEG_MIN, INTEG_MAX);
      i = (longint'(ki) * integral) / 256000000;
      if (last_error == 0) d = 0;
      else d = (longint'(kd) * (err - last_error) * 1000000) / (256 * ts);
      last_error = err;
      sig = clamp(p + i + d, -8388608, 8388607);
      base = longint'(base_speed) * 256;
      r.signal = sig[23:0];
      r.left = 16'(clamp((base + sig) / 256, -32768, 32767));
      r.right = 16'(clamp((base - sig) / 256, -32768, 32767));
      r.seen = (cnt > 0);
      return r;
   endfunction

   function automatic steer_t mk(int s, int l, int r, bit seen);
      steer_t t;
      t.signal = 24'(s); t.left = 16'(l); t.right = 16'(r); t.seen = seen;
      return t;
   endfunction

   function automatic row_t item(logic [7:0] b);
      row_t r;
      r.is_csr = 0; r.bits = b; r.typed = 0; r.want = '0; r.idx = '0; r.data = '0;
      return r;
   endfunction

   function automatic row_t item_t(logic [7:0] b, steer_t w);
      row_t r;
      r = item(b); r.typed = 1; r.want = w;
      return r;
   endfunction

   function automatic row_t csr(logic [2:0] i, logic [19:0] d);
      row_t r;
      r = item('0); r.is_csr = 1; r.idx = i; r.data = d;
      return r;
   endfunction

   task automatic wait_idle();
      while (steer_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] i, logic [19:0] d);
      @(negedge clock);
      csr_write_en = 1'b1; csr_index = i; csr_write_data = d;
      case (i)
         CSR_GAIN_P:   kp = d[15:0];
         CSR_GAIN_I:   ki = d[15:0];
         CSR_GAIN_D:   kd = d[15:0];
         CSR_TIMESTEP: period_us = d;
         CSR_SPEED:    base_speed = d[14:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic send(logic [7:0] b, bit typed, steer_t w);
      while (!no_idle && $urandom_range(99) < 25) @(negedge clock);
      req_valid = 1'b1; req_sensor_bits = b; cur_typed = typed; cur_want = w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic logic [19:0] pick_gain();
      case ($urandom_range(4))
         0: return 20'h07FFF;
         1: return 20'h08000;
         2: return 20'($urandom_range(512));
         3: return 20'(-$urandom_range(512));
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic logic [19:0] pick_period();
      case ($urandom_range(3))
         0: return 20'd0;
         1: return 20'd1;
         2: return 20'd1000000;
         default: return 20'($urandom_range(1000000, 1));
      endcase
   endfunction

   function automatic logic [7:0] pick_bits(int mode);
      case (mode)
         1: return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15, 1));
         2: return ($urandom_range(3) == 0) ? 8'($urandom) : {4'($urandom_range(15, 1)), 4'h0};
         default: return 8'($urandom);
      endcase
   endfunction

   // request driver
   initial begin
      rows = '{
         item_t(8'h00, mk(0, 0, 0, 0)),
         item_t(8'h01, mk(-896, -3, 3, 1)),
         item_t(8'h80, mk(896, 3, -3, 1)),
         item_t(8'hFF, mk(0, 0, 0, 1)),
         csr(CSR_GAIN_D, 20'h07FFF), csr(CSR_GAIN_I, 20'h07FFF),
         csr(CSR_TIMESTEP, 20'd0), csr(CSR_SPEED, 20'h7FFF), csr(CSR_GAIN_P, 20'h08000),
         item(8'h01), item(8'h80), item(8'h01), item(8'h18), item(8'h00), item(8'hC0),
         csr(CSR_TIMESTEP, 20'd1000000), csr(CSR_GAIN_P, 20'h07FFF),
         csr(CSR_GAIN_D, 20'h08000), csr(CSR_GAIN_I, 20'h08000), csr(CSR_SPEED, 20'd0),
         csr(3'd5, 20'hFFFFF),
         item(8'h80), item(8'h01), item(8'h3C), item(8'h7F), item(8'hFE)
      };
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (rows[k]) begin
         if (rows[k].is_csr) begin
            wait_idle();
            csr_write(rows[k].idx, rows[k].data);
         end else begin
            send(rows[k].bits, rows[k].typed, rows[k].want);
         end
      end
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         csr_write(CSR_GAIN_P, pick_gain());
         csr_write(CSR_GAIN_I, pick_gain());
         csr_write(CSR_GAIN_D, pick_gain());
         csr_write(CSR_TIMESTEP, (ph < 2) ? 20'd1000000 : pick_period());
         csr_write(CSR_SPEED, ($urandom_range(2) == 0) ? 20'h7FFF : 20'($urandom_range(32767)));
         for (int n = 0; n < 272; n++)
            send(pick_bits(ph < 2 ? 1 : (ph == 3 ? 2 : 0)), 0, '0);
      end
      while (steer_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("line_centroid_pid_steering_core_tb passed");
      else $display("line_centroid_pid_steering_core_tb failed");
      $finish;
   end

   // result receiver
   initial begin
      bit held = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held && accepted >= 200) begin
            held = 1;
            rsp_ready = 1'b0;
            repeat (2000) @(negedge clock);
         end
         rsp_ready = no_idle || ($urandom_range(99) >= 25);
      end
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      steer_t got, want, pred;
      if (!reset) begin
         no_idle <= (accepted >= 600 && accepted < 800);
         if (req_valid && req_ready) begin
            pred = steer_predict(req_sensor_bits);
            steer_q.push_back(cur_typed ? cur_want : pred);
            accepted <= accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_control_signal, rsp_left_speed, rsp_right_speed, rsp_line_seen};
            if (steer_q.size() == 0) begin
               $display("%t: unexpected result %h", $realtime, got);
               errors++;
            end else begin
               want = steer_q.pop_front();
               if (got.signal !== want.signal) begin
                  $display("%t: signal exp %0d got %0d", $realtime, want.signal, got.signal);
                  errors++;
               end
               if (got.left !== want.left) begin
                  $display("%t: left exp %0d got %0d", $realtime, want.left, got.left);
                  errors++;
               end
               if (got.right !== want.right) begin
                  $display("%t: right exp %0d got %0d", $realtime, want.right, got.right);
                  errors++;
               end
               if (got.seen !== want.seen) begin
                  $display("%t: seen exp %0b got %0b", $realtime, want.seen, got.seen);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("line_centroid_pid_steering_core_tb failed");
      $finish;
   end

endmodule
